// ----- hdl/sdaq_pkg.sv -----
// codes shared by the sorted deadline alarm queue
`default_nettype none

package sdaq_pkg;

  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 3;

  localparam logic [KIND_BITS-1:0] KIND_SET       = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_CANCEL    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_POLL_ABS  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_POLL_DLY  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_PROCESS   = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_PENDING  = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_FIRED    = 3'd4;
  localparam logic [STATUS_BITS-1:0] STATUS_FINISHED = 3'd5;

  typedef enum logic [1:0] {
    PLACE_FREE    = 2'd0,
    PLACE_WAITING = 2'd1,
    PLACE_READY   = 2'd2,
    PLACE_DONE    = 2'd3
  } place_t;

endpackage

`default_nettype wire

// ----- hdl/sdaq_tcmp.sv -----
// wrap-aware time compare and difference, shared by all requests
`default_nettype none

module sdaq_tcmp #(
  parameter int TIME_BITS = 32
) (
  input  wire logic [TIME_BITS-1:0] a,
  input  wire logic [TIME_BITS-1:0] b,
  output logic                      less,
  output logic [TIME_BITS-1:0]      diff
);

  localparam logic [TIME_BITS-1:0] HALF_UP = {1'b1, {(TIME_BITS-1){1'b0}}};

  // a earlier than b when b - a lies in 1 .. 2^(n-1)
  assign diff = b - a;
  assign less = (diff != '0) && (diff <= HALF_UP);

endmodule

`default_nettype wire

// ----- hdl/sorted_deadline_alarm_queue.sv -----
// sorted deadline alarm queue: sequencer, entry stores and output register
//
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid in_stall kind time_value handle user_tag   | request in
//          | fire_limit                                          |
//  out     | out_valid out_stall status handle_out tag_out       | result out
//          | time_out fired_count last                           |
//
// one request at a time; in_stall is high while the sequencer works.
// set: free scan, then each entry with a later deadline moves back one place.
// cancel: frees the entry, searches the order list, shifts the rest down.
// poll: reads and compares the head entry; process: fires due alarms in turn.
// all share one compare unit and one port of each store.
// reset frees all entries at once; a stalled output holds the sequencer.
`default_nettype none

module sorted_deadline_alarm_queue
  import sdaq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [KIND_BITS-1:0]             kind,
  input  wire logic [TIME_BITS-1:0]             time_value,
  input  wire logic [$clog2(DEPTH)-1:0]         handle,
  input  wire logic [TAG_BITS-1:0]              user_tag,
  input  wire logic [$clog2(DEPTH+1)-1:0]       fire_limit,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [STATUS_BITS-1:0]                status,
  output logic [$clog2(DEPTH)-1:0]              handle_out,
  output logic [TAG_BITS-1:0]                   tag_out,
  output logic [TIME_BITS-1:0]                  time_out,
  output logic [$clog2(DEPTH+1)-1:0]            fired_count,
  output logic                                  last
);

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_INS, S_ILD, S_ICMP, S_CAN, S_URD, S_UCHK,
    S_USH, S_UWR, S_PCHK, S_HEAD, S_HLD, S_HCMP, S_FIRE, S_REPLY
  } state_t;

  state_t state;

  logic [TIME_BITS-1:0] dl_mem  [DEPTH];
  logic [TAG_BITS-1:0]  tag_mem [DEPTH];
  logic [IDX_BITS-1:0]  ord_mem [DEPTH];
  place_t               place   [DEPTH];

  logic [KIND_BITS-1:0]   kind_r;
  logic [TIME_BITS-1:0]   tv_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic [IDX_BITS-1:0]    hnd_r;
  logic [CNT_BITS-1:0]    lim_r;
  logic [IDX_BITS-1:0]    fh;
  logic [CNT_BITS-1:0]    pos;
  logic [CNT_BITS-1:0]    wcount;
  logic [CNT_BITS-1:0]    fired;
  logic [IDX_BITS-1:0]    ord_q;
  logic [TIME_BITS-1:0]   dl_q;
  logic [TAG_BITS-1:0]    tg_q;

  logic [STATUS_BITS-1:0] res_status;
  logic [IDX_BITS-1:0]    res_h;
  logic [TIME_BITS-1:0]   res_t;
  logic [CNT_BITS-1:0]    res_c;

  logic                   less;
  logic [TIME_BITS-1:0]   diff;
  logic                   out_free;
  logic                   load_out;
  logic [CNT_BITS-1:0]    pos_inc;
  logic [CNT_BITS-1:0]    pos_dec;
  logic [IDX_BITS-1:0]    pidx;

  sdaq_tcmp #(.TIME_BITS(TIME_BITS)) u_tcmp (
    .a    (tv_r),
    .b    (dl_q),
    .less (less),
    .diff (diff)
  );

  assign out_free = !out_valid || !out_stall;
  assign load_out = ((state == S_FIRE) || (state == S_REPLY)) && out_free;
  assign in_stall = rst || (state != S_IDLE);
  assign pos_inc  = pos + 1'b1;
  assign pos_dec  = pos - 1'b1;
  assign pidx     = pos[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wcount    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        place[i] <= PLACE_FREE;
      end
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= kind;
            tv_r       <= time_value;
            tag_r      <= user_tag;
            hnd_r      <= handle;
            lim_r      <= fire_limit;
            fired      <= '0;
            res_status <= ((kind == KIND_POLL_ABS || kind == KIND_POLL_DLY) && wcount == '0) ?
                          STATUS_EMPTY : STATUS_OK;
            res_h      <= (kind == KIND_CANCEL) ? handle : '0;
            res_t      <= '0;
            res_c      <= '0;
            pos        <= (kind == KIND_CANCEL) ? CNT_BITS'(handle) : '0;
            case (kind)
              KIND_SET: state <= S_SCAN;
              KIND_CANCEL: begin
                if (CNT_BITS'(handle) < CNT_BITS'(DEPTH)) begin
                  state <= S_CAN;
                end else begin
                  state <= S_REPLY;
                end
              end
              KIND_POLL_ABS, KIND_POLL_DLY: begin
                if (wcount == '0) begin
                  state <= S_REPLY;
                end else begin
                  state <= S_HEAD;
                end
              end
              KIND_PROCESS: state <= S_PCHK;
              default: state <= S_REPLY;
            endcase
          end
        end
        S_SCAN: begin
          if (place[pidx] == PLACE_FREE) begin
            fh            <= pidx;
            dl_mem[pidx]  <= tv_r;
            tag_mem[pidx] <= tag_r;
            place[pidx]   <= PLACE_WAITING;
            pos           <= wcount;
            state         <= S_INS;
          end else if (pos == CNT_BITS'(DEPTH - 1)) begin
            res_status <= STATUS_FULL;
            state      <= S_REPLY;
          end else begin
            pos <= pos_inc;
          end
        end
        S_INS: begin
          if (pos == '0) begin
            ord_mem[pidx] <= fh;
            wcount        <= wcount + 1'b1;
            res_h         <= fh;
            state         <= S_REPLY;
          end else begin
            ord_q <= ord_mem[pos_dec[IDX_BITS-1:0]];
            state <= S_ILD;
          end
        end
        S_ILD: begin
          dl_q  <= dl_mem[ord_q];
          state <= S_ICMP;
        end
        S_ICMP: begin
          // new deadline earlier: move this entry back one place
          if (less) begin
            ord_mem[pidx] <= ord_q;
            pos           <= pos_dec;
            state         <= S_INS;
          end else begin
            ord_mem[pidx] <= fh;
            wcount        <= wcount + 1'b1;
            res_h         <= fh;
            state         <= S_REPLY;
          end
        end
        S_CAN: begin
          place[pidx] <= PLACE_FREE;
          pos         <= '0;
          if (place[pidx] == PLACE_WAITING) begin
            state <= S_URD;
          end else begin
            state <= S_REPLY;
          end
        end
        S_URD: begin
          if (pos >= wcount) begin
            state <= S_REPLY;
          end else begin
            ord_q <= ord_mem[pidx];
            state <= S_UCHK;
          end
        end
        S_UCHK: begin
          if (ord_q == hnd_r) begin
            state <= S_USH;
          end else begin
            pos   <= pos_inc;
            state <= S_URD;
          end
        end
        S_USH: begin
          if (pos_inc < wcount) begin
            ord_q <= ord_mem[pos_inc[IDX_BITS-1:0]];
            state <= S_UWR;
          end else begin
            wcount <= wcount - 1'b1;
            state  <= (kind_r == KIND_PROCESS) ? S_PCHK : S_REPLY;
          end
        end
        S_UWR: begin
          ord_mem[pidx] <= ord_q;
          pos           <= pos_inc;
          state         <= S_USH;
        end
        S_PCHK: begin
          if (wcount == '0 || (lim_r != '0 && fired >= lim_r)) begin
            res_status <= STATUS_FINISHED;
            res_c      <= fired;
            state      <= S_REPLY;
          end else begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          ord_q <= ord_mem[0];
          state <= S_HLD;
        end
        S_HLD: begin
          dl_q  <= dl_mem[ord_q];
          tg_q  <= tag_mem[ord_q];
          state <= S_HCMP;
        end
        S_HCMP: begin
          if (kind_r == KIND_PROCESS) begin
            if (less) begin
              res_status <= STATUS_FINISHED;
              res_c      <= fired;
              state      <= S_REPLY;
            end else begin
              place[ord_q] <= PLACE_DONE;
              state        <= S_FIRE;
            end
          end else begin
            if (less) begin
              res_status <= STATUS_OK;
              res_t      <= (kind_r == KIND_POLL_ABS) ? dl_q : diff;
            end else begin
              res_status <= STATUS_PENDING;
              res_t      <= (kind_r == KIND_POLL_ABS) ? tv_r : '0;
            end
            state <= S_REPLY;
          end
        end
        S_FIRE: begin
          if (out_free) begin
            status      <= STATUS_FIRED;
            handle_out  <= ord_q;
            tag_out     <= tg_q;
            time_out    <= '0;
            fired_count <= '0;
            last        <= 1'b0;
            fired       <= fired + 1'b1;
            hnd_r       <= ord_q;
            pos         <= '0;
            // head of the list leaves: shift the rest down
            state       <= S_USH;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            status      <= res_status;
            handle_out  <= res_h;
            tag_out     <= '0;
            time_out    <= res_t;
            fired_count <= res_c;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wcount <= CNT_BITS'(DEPTH))
    else $error("waiting count beyond depth");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FIRED |-> !last)
    else $error("fired result marked last");

  a_head_waiting: assert property (@(posedge clk) disable iff (rst)
    state == S_HCMP |-> place[ord_q] == PLACE_WAITING)
    else $error("head of list is not a waiting entry");

  a_fire_follows: assert property (@(posedge clk) disable iff (rst)
    state == S_FIRE && out_free |=> out_valid && status == STATUS_FIRED)
    else $error("fired alarm not presented");

endmodule

`default_nettype wire

// ----- tb/sv/sorted_deadline_alarm_queue_tb.sv -----
// self-checking testbench for the sorted deadline alarm queue
`default_nettype none

module sorted_deadline_alarm_queue_tb;
  import sdaq_pkg::*;

  localparam int ALARM_SLOTS = 16;
  localparam int IDLE_LIMIT  = 5000;
  localparam int RANDOM_REQS = 72;
  localparam logic [31:0] HALF_SPAN = 32'h7fff_ffff;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tv;
    logic [3:0]  hnd;
    logic [15:0] tag;
    logic [4:0]  lim;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  hnd;
    logic [15:0] tag;
    logic [31:0] tm;
    logic [4:0]  cnt;
    logic        last;
  } answer_t;

  typedef struct {
    request_t req;
    int       rep;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [31:0] time_value = '0;
  logic [3:0] handle = '0;
  logic [15:0] user_tag = '0;
  logic [4:0] fire_limit = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic [3:0] handle_out;
  logic [15:0] tag_out;
  logic [31:0] time_out;
  logic [4:0] fired_count;
  logic last;

  // typed answer that travels with the request on the wire
  bit typed_cur = 0;
  answer_t typed_ans = '0;

  sorted_deadline_alarm_queue dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .time_value(time_value), .handle(handle), .user_tag(user_tag),
    .fire_limit(fire_limit), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .handle_out(handle_out), .tag_out(tag_out), .time_out(time_out),
    .fired_count(fired_count), .last(last)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // shadow of the alarm store
  logic [31:0] slot_deadline [ALARM_SLOTS];
  logic [15:0] slot_tag [ALARM_SLOTS];
  place_t      slot_place [ALARM_SLOTS];
  logic [3:0]  sorted_handles [ALARM_SLOTS];
  int          sorted_count;

  answer_t pending_answers [$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d > HALF_SPAN;
  endfunction

  function automatic answer_t mk(logic [2:0] st, logic [3:0] h, logic [15:0] tg,
                                 logic [31:0] tm, logic [4:0] cnt, logic lst);
    answer_t a;
    a = '{st, h, tg, tm, cnt, lst};
    return a;
  endfunction

  function automatic void drop_sorted(logic [3:0] h);
    int i;
    int j;
    for (i = 0; i < sorted_count; i++) begin
      if (sorted_handles[i] == h) begin
        for (j = i; j + 1 < sorted_count; j++) sorted_handles[j] = sorted_handles[j + 1];
        sorted_count--;
        return;
      end
    end
  endfunction

  function automatic void predict_alarms(request_t r);
    int h;
    int pos;
    int fired;
    logic [31:0] due;
    logic [3:0] top;
    case (r.kind)
      KIND_SET: begin
        h = ALARM_SLOTS;
        for (int i = ALARM_SLOTS - 1; i >= 0; i--) if (slot_place[i] == PLACE_FREE) h = i;
        if (h >= ALARM_SLOTS || sorted_count >= ALARM_SLOTS) begin
          pending_answers.push_back(mk(STATUS_FULL, 0, 0, 0, 0, 1));
        end else begin
          slot_deadline[h] = r.tv;
          slot_tag[h] = r.tag;
          slot_place[h] = PLACE_WAITING;
          pos = sorted_count;
          while (pos > 0 && is_earlier(r.tv, slot_deadline[sorted_handles[pos - 1]])) pos--;
          for (int j = sorted_count; j > pos; j--) sorted_handles[j] = sorted_handles[j - 1];
          sorted_handles[pos] = 4'(h);
          sorted_count++;
          pending_answers.push_back(mk(STATUS_OK, 4'(h), 0, 0, 0, 1));
        end
      end
      KIND_CANCEL: begin
        if (slot_place[r.hnd] == PLACE_WAITING) drop_sorted(r.hnd);
        slot_place[r.hnd] = PLACE_FREE;
        pending_answers.push_back(mk(STATUS_OK, r.hnd, 0, 0, 0, 1));
      end
      KIND_POLL_ABS, KIND_POLL_DLY: begin
        if (sorted_count == 0) begin
          pending_answers.push_back(mk(STATUS_EMPTY, 0, 0, 0, 0, 1));
        end else begin
          due = slot_deadline[sorted_handles[0]];
          if (!is_earlier(r.tv, due))
            pending_answers.push_back(mk(STATUS_PENDING, 0, 0,
                                         (r.kind == KIND_POLL_ABS) ? r.tv : 32'd0, 0, 1));
          else
            pending_answers.push_back(mk(STATUS_OK, 0, 0,
                                         (r.kind == KIND_POLL_ABS) ? due : due - r.tv, 0, 1));
        end
      end
      KIND_PROCESS: begin
        fired = 0;
        while (sorted_count > 0 && (r.lim == 0 || fired < r.lim)) begin
          top = sorted_handles[0];
          if (is_earlier(r.tv, slot_deadline[top])) break;
          drop_sorted(top);
          slot_place[top] = PLACE_DONE;
          pending_answers.push_back(mk(STATUS_FIRED, top, slot_tag[top], 0, 0, 0));
          fired++;
        end
        pending_answers.push_back(mk(STATUS_FINISHED, 0, 0, 0, 5'(fired), 1));
      end
      default: pending_answers.push_back(mk(STATUS_OK, 0, 0, 0, 0, 1));
    endcase
  endfunction

  // prediction at acceptance, checking of results, idle watchdog
  always @(posedge clk) begin
    answer_t want;
    int before_n;
    if (rst) begin
      for (int i = 0; i < ALARM_SLOTS; i++) slot_place[i] = PLACE_FREE;
      sorted_count = 0;
      idle_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        before_n = pending_answers.size();
        predict_alarms('{kind, time_value, handle, user_tag, fire_limit});
        if (typed_cur) begin
          while (pending_answers.size() > before_n) void'(pending_answers.pop_back());
          pending_answers.push_back(typed_ans);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("result with nothing expected: status %0d", status);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (status !== want.status) begin
            $error("status exp %0d got %0d", want.status, status); errors++;
          end
          if (handle_out !== want.hnd) begin
            $error("handle_out exp %0d got %0d", want.hnd, handle_out); errors++;
          end
          if (tag_out !== want.tag) begin
            $error("tag_out exp %0h got %0h", want.tag, tag_out); errors++;
          end
          if (time_out !== want.tm) begin
            $error("time_out exp %0h got %0h", want.tm, time_out); errors++;
          end
          if (fired_count !== want.cnt) begin
            $error("fired_count exp %0d got %0d", want.cnt, fired_count); errors++;
          end
          if (last !== want.last) begin
            $error("last exp %0d got %0d", want.last, last); errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[sorted_deadline_alarm_queue] ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern: runs of stall or no stall, some long clear stretches
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(20, 60);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        stall_run <= $urandom_range(1, 6);
      end
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  int burst_left = 0;
  logic [31:0] now_time = 32'd0;

  task automatic send_request(request_t r, bit typed, answer_t a);
    int gap;
    in_valid <= 1'b1;
    kind <= r.kind;
    time_value <= r.tv;
    handle <= r.hnd;
    user_tag <= r.tag;
    fire_limit <= r.lim;
    typed_cur <= typed;
    typed_ans <= a;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.tv = $urandom;
    r.hnd = 4'($urandom_range(0, 15));
    r.tag = 16'($urandom);
    r.lim = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      r.kind = KIND_SET;
      if ($urandom_range(0, 7) != 0) r.tv = now_time + $urandom_range(0, 600);
    end else if (pick < 56) begin
      r.kind = KIND_CANCEL;
    end else if (pick < 95) begin
      r.kind = (pick < 66) ? KIND_POLL_ABS : (pick < 76) ? KIND_POLL_DLY : KIND_PROCESS;
      now_time = now_time + $urandom_range(0, 300);
      if ($urandom_range(0, 7) != 0) r.tv = now_time;
    end else begin
      r.kind = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  initial begin
    row_t rows [$];
    request_t r;
    rows.push_back('{'{KIND_POLL_ABS, 32'd0, 4'd0, 16'd0, 5'd0}, 1, 1,
                     mk(STATUS_EMPTY, 0, 0, 0, 0, 1)});
    rows.push_back('{'{KIND_POLL_DLY, 32'hffff_ffff, 4'd15, 16'hffff, 5'd31}, 1, 1,
                     mk(STATUS_EMPTY, 0, 0, 0, 0, 1)});
    rows.push_back('{'{KIND_PROCESS, 32'hffff_ffff, 4'd0, 16'd0, 5'd0}, 1, 1,
                     mk(STATUS_FINISHED, 0, 0, 0, 0, 1)});
    rows.push_back('{'{3'd5, 32'hffff_ffff, 4'd15, 16'hffff, 5'd31}, 1, 1,
                     mk(STATUS_OK, 0, 0, 0, 0, 1)});
    rows.push_back('{'{3'd6, 32'd1, 4'd1, 16'd1, 5'd1}, 1, 1, mk(STATUS_OK, 0, 0, 0, 0, 1)});
    rows.push_back('{'{3'd7, 32'd0, 4'd0, 16'd0, 5'd0}, 1, 1, mk(STATUS_OK, 0, 0, 0, 0, 1)});
    // cancelling a free entry
    rows.push_back('{'{KIND_CANCEL, 32'd0, 4'd15, 16'd0, 5'd0}, 1, 1,
                     mk(STATUS_OK, 15, 0, 0, 0, 1)});
    rows.push_back('{'{KIND_SET, 32'd0, 4'd0, 16'hffff, 5'd0}, 1, 1,
                     mk(STATUS_OK, 0, 0, 0, 0, 1)});
    rows.push_back('{'{KIND_SET, 32'hffff_ffff, 4'd0, 16'h0, 5'd0}, 1, 1,
                     mk(STATUS_OK, 1, 0, 0, 0, 1)});
    // equal deadlines leave in arrival order
    rows.push_back('{'{KIND_SET, 32'd100, 4'd0, 16'h0001, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_SET, 32'd100, 4'd0, 16'h0002, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_POLL_ABS, 32'd50, 4'd0, 16'd0, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_POLL_DLY, 32'hffff_fff0, 4'd0, 16'd0, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_POLL_ABS, 32'd200, 4'd0, 16'd0, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_POLL_DLY, 32'd200, 4'd0, 16'd0, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_PROCESS, 32'd100, 4'd0, 16'd0, 5'd1}, 1, 0, '0});
    rows.push_back('{'{KIND_PROCESS, 32'd200, 4'd0, 16'd0, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_CANCEL, 32'd0, 4'd0, 16'd0, 5'd0}, 1, 0, '0});
    rows.push_back('{'{KIND_CANCEL, 32'd0, 4'd2, 16'd0, 5'd0}, 1, 0, '0});
    // fill the store until it reports full
    rows.push_back('{'{KIND_SET, 32'd1000, 4'd0, 16'h5a5a, 5'd0}, 17, 0, '0});
    rows.push_back('{'{KIND_PROCESS, 32'h8000_0000, 4'd0, 16'd0, 5'd31}, 1, 0, '0});
    rows.push_back('{'{KIND_PROCESS, 32'd1000, 4'd0, 16'd0, 5'd16}, 1, 0, '0});
    rows.push_back('{'{KIND_SET, 32'd2000, 4'd0, 16'ha5a5, 5'd0}, 1, 0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].rep; k++) begin
        r = rows[i].req;
        r.tag = 16'(r.tag + k);
        send_request(r, rows[i].typed, rows[i].ans);
      end
    end
    drain_results();

    now_time = 32'd3000;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      send_request(random_request(), 1'b0, '0);
      if (n == RANDOM_REQS / 2) drain_results();
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("[sorted_deadline_alarm_queue] OK");
    end else begin
      $display("[sorted_deadline_alarm_queue] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/sdaq_pkg.sv
hdl/sdaq_tcmp.sv
hdl/sorted_deadline_alarm_queue.sv
tb/sv/sorted_deadline_alarm_queue_tb.sv
